### rtl/tls_pkg.sv
`default_nettype none

package tls_pkg;

	localparam int CntW = 16;
	localparam int CfgW = 16;
	localparam int CmpW = (CntW + 1 > CfgW) ? CntW + 1 : CfgW;

	localparam logic [CfgW-1:0] ShortReset = CfgW'(43);
	localparam logic [CfgW-1:0] LongReset  = CfgW'(43 * 5);

	// configuration register indexes
	localparam logic REG_SHORT = 1'b0;
	localparam logic REG_LONG  = 1'b1;

	// phase codes, as reported on phase_now
	localparam logic [3:0] PH_B_GREEN   = 4'd0;
	localparam logic [3:0] PH_B1_AMBER  = 4'd1;
	localparam logic [3:0] PH_M1_AMB_A  = 4'd2;
	localparam logic [3:0] PH_M_GREEN   = 4'd3;
	localparam logic [3:0] PH_M1_AMB_B  = 4'd4;
	localparam logic [3:0] PH_T1_AMB_A  = 4'd5;
	localparam logic [3:0] PH_T_GREEN   = 4'd6;
	localparam logic [3:0] PH_T1_AMB_B  = 4'd7;
	localparam logic [3:0] PH_TO_RED    = 4'd8;
	localparam logic [3:0] PH_ALL_RED   = 4'd9;
	localparam logic [3:0] PH_TO_START  = 4'd10;
	localparam logic [3:0] PH_ALL_AMBER = 4'd11;

	// pending request bits
	localparam int PEND_B = 0;
	localparam int PEND_M = 1;
	localparam int PEND_T = 2;

	typedef struct packed {
		logic car_t;
		logic car_m;
		logic car_n;
		logic car_b;
		logic emerg_t;
		logic emerg_m;
		logic emerg_b;
		logic tick;
	} item_t;

	typedef struct packed {
		logic       decided;
		logic [3:0] phase_now;
		logic [7:0] green_mask;
		logic [7:0] amber_mask;
		logic [7:0] red_mask;
	} result_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [2:0] pend;
	} status_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] amber;
		logic [7:0] green;
		logic       is_long;
	} lamps_t;

	// lamp masks, bit0..7 = B1,B2,N1,N2,M1,M2,T1,T2
	function automatic lamps_t phase_lamps(input logic [3:0] ph);
		lamps_t l;
		unique case (ph)
			PH_B_GREEN:   l = '{8'h54, 8'h00, 8'hAB, 1'b1};
			PH_B1_AMBER:  l = '{8'h54, 8'h01, 8'hAA, 1'b0};
			PH_M1_AMB_A:  l = '{8'h45, 8'h10, 8'hAA, 1'b0};
			PH_M_GREEN:   l = '{8'h45, 8'h00, 8'hBA, 1'b1};
			PH_M1_AMB_B:  l = '{8'h45, 8'h10, 8'hAA, 1'b0};
			PH_T1_AMB_A:  l = '{8'h15, 8'h40, 8'hAA, 1'b0};
			PH_T_GREEN:   l = '{8'h15, 8'h00, 8'hEA, 1'b1};
			PH_T1_AMB_B:  l = '{8'h15, 8'h40, 8'hAA, 1'b0};
			PH_TO_RED:    l = '{8'h55, 8'hAA, 8'h00, 1'b0};
			PH_ALL_RED:   l = '{8'hFF, 8'h00, 8'h00, 1'b1};
			PH_TO_START:  l = '{8'h54, 8'hAB, 8'h00, 1'b0};
			PH_ALL_AMBER: l = '{8'h00, 8'hFF, 8'h00, 1'b0};
			default:      l = '{8'h54, 8'h00, 8'hAB, 1'b1};
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

### rtl/tls_core.sv
`default_nettype none

module tls_core import tls_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire item_t           item,
	input  wire logic [CfgW-1:0] short_ticks,
	input  wire logic [CfgW-1:0] long_ticks,
	output result_t              res,
	output status_t              st
);

	logic [3:0]      phase_q;
	logic [CntW-1:0] ticks_q;
	logic [2:0]      pend_q;

	logic [2:0]      pend;
	logic [2:0]      pend_next;
	logic [3:0]      phase_next;
	logic [CntW-1:0] ticks_next;
	logic [CntW:0]   nxt;
	logic [CfgW-1:0] dur;
	logic            ends;
	logic            traffic;
	logic            any_vehicle;
	lamps_t          cur;
	lamps_t          shown;

	always_comb begin
		pend        = pend_q | {item.emerg_t, item.emerg_m, item.emerg_b};
		traffic     = item.car_t | item.car_n | item.car_m;
		any_vehicle = traffic | item.car_b;
		cur         = phase_lamps(phase_q);
		dur         = cur.is_long ? long_ticks : short_ticks;
		nxt         = {1'b0, ticks_q} + (CntW+1)'(1);

		// a preempting request ends any phase but all-amber before the tick counts
		priority if (phase_q > PH_ALL_AMBER) begin
			ends = 1'b1;
		end else if (phase_q != PH_ALL_AMBER && pend != 3'b000) begin
			ends = 1'b1;
		end else if (item.tick) begin
			ends = (CmpW'(nxt) >= CmpW'(dur)) || (CmpW'(nxt) >= CmpW'({CntW{1'b1}}));
		end else begin
			ends = 1'b0;
		end

		if (ends)
			ticks_next = '0;
		else if (item.tick)
			ticks_next = nxt[CntW-1:0];
		else
			ticks_next = ticks_q;

		pend_next  = pend;
		phase_next = phase_q;
		if (ends) begin
			unique case (phase_q)
				PH_B_GREEN: begin
					if (pend[PEND_B]) begin
						pend_next[PEND_B] = 1'b0;
						phase_next = PH_B_GREEN;
					end else if (pend != 3'b000) begin
						phase_next = PH_ALL_AMBER;
					end else begin
						phase_next = traffic ? PH_B1_AMBER : PH_B_GREEN;
					end
				end
				PH_M_GREEN: begin
					if (pend[PEND_M]) begin
						pend_next[PEND_M] = 1'b0;
						phase_next = PH_M_GREEN;
					end else if (pend != 3'b000) begin
						phase_next = PH_ALL_AMBER;
					end else begin
						phase_next = traffic ? PH_M1_AMB_B : PH_M_GREEN;
					end
				end
				PH_T_GREEN: begin
					if (pend[PEND_T]) begin
						pend_next[PEND_T] = 1'b0;
						phase_next = PH_T_GREEN;
					end else if (pend != 3'b000) begin
						phase_next = PH_ALL_AMBER;
					end else begin
						phase_next = traffic ? PH_T1_AMB_B : PH_T_GREEN;
					end
				end
				PH_B1_AMBER, PH_M1_AMB_A, PH_M1_AMB_B, PH_T1_AMB_A, PH_T1_AMB_B,
				PH_TO_RED: begin
					phase_next = (pend != 3'b000) ? PH_ALL_AMBER : phase_q + 4'd1;
				end
				PH_TO_START: begin
					phase_next = (pend != 3'b000) ? PH_ALL_AMBER : PH_B_GREEN;
				end
				PH_ALL_RED: begin
					if (pend != 3'b000)
						phase_next = PH_ALL_AMBER;
					else
						phase_next = any_vehicle ? PH_TO_START : PH_ALL_RED;
				end
				PH_ALL_AMBER: begin
					// serve B first, then M, then T
					priority if (pend[PEND_B]) begin
						pend_next[PEND_B] = 1'b0;
						phase_next = PH_B_GREEN;
					end else if (pend[PEND_M]) begin
						pend_next[PEND_M] = 1'b0;
						phase_next = PH_M_GREEN;
					end else if (pend[PEND_T]) begin
						pend_next[PEND_T] = 1'b0;
						phase_next = PH_T_GREEN;
					end else begin
						phase_next = PH_B_GREEN;
					end
				end
				default: phase_next = PH_B_GREEN;
			endcase
		end

		shown         = phase_lamps(phase_next);
		res.red_mask   = shown.red;
		res.amber_mask = shown.amber;
		res.green_mask = shown.green;
		res.phase_now  = phase_next;
		res.decided    = ends;

		st.phase = phase_q;
		st.pend  = pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_B_GREEN;
			ticks_q <= '0;
			pend_q  <= 3'b000;
		end else if (advance) begin
			phase_q <= phase_next;
			ticks_q <= ticks_next;
			pend_q  <= pend_next;
		end
	end

endmodule

`default_nettype wire

### rtl/traffic_light_sequencer_with_preemption.sv
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: tick, emergency b/m/t, vehicle b/n/m/t
// m_       out  m_tvalid/m_tready  m_tdata: red, amber, green masks, phase, decided
// cfg_     in   cfg_we             cfg_index, cfg_data (short_ticks, long_ticks)
//
// One item per clock sustained while results are taken; each item passes through
// the input register and then the result register.
// The phase step is one pass of logic between the two registers.
// A stalled result holds in the output register while an empty input register still
// takes a new item; the step runs once the result is free or being taken.
// arst_n clears phase, tick count, pending requests and both valid flags.
`default_nettype none

module traffic_light_sequencer_with_preemption import tls_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,   // tick, emerg_b, emerg_m, emerg_t, car_b,
	                                        // car_n, car_m, car_t
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [31:0]          m_tdata,   // red_mask[7:0], amber_mask[15:8], green_mask[23:16],
	                                        // phase_now[27:24], decided[28], zeros
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [CfgW-1:0] cfg_data
);

	item_t           item_s1;
	logic            valid_s1;
	result_t         res_q;
	logic            out_valid_q;
	logic [CfgW-1:0] short_q;
	logic [CfgW-1:0] long_q;

	logic            advance;
	logic            s_xfer;
	result_t         step_res;
	status_t         st;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q};

	tls_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.short_ticks (short_q),
		.long_ticks  (long_q),
		.res         (step_res),
		.st          (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_xfer)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer)
			item_s1 <= item_t'(s_tdata);
		if (advance)
			res_q <= step_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= ShortReset;
			long_q  <= LongReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT: short_q <= cfg_data;
				REG_LONG:  long_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

`ifndef SYNTH
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_q.phase_now <= PH_ALL_AMBER)
		else $error("result phase out of range");

	a_hold_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !step_res.decided |-> step_res.phase_now == st.phase)
		else $error("phase moved without a decision");

	a_amber_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res.decided && step_res.phase_now == PH_ALL_AMBER
		|=> st.pend != 3'b000)
		else $error("all-amber entered with no request pending");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with result register empty");
`endif

endmodule

`default_nettype wire
